@@ design/e2r_pkg.sv @@
`timescale 1ns / 1ps
package e2r_pkg;

    localparam int ANG_W             = 16;
    localparam int ELEM_W            = 16;
    localparam int DEF_OUT_FRAC_BITS = 14;

    // sine/cosine lane: 42 staged registers plus the result register
    localparam int SC_STAGES   = 43;
    localparam int MX_STAGES   = 5;
    localparam int PIPE_STAGES = SC_STAGES + MX_STAGES;

    // angle steps (1/64 degree)
    localparam logic [16:0] TURN_STEPS    = 17'd23040;
    localparam logic [16:0] QUARTER_STEPS = 17'd5760;
    localparam logic [16:0] EIGHTH_STEPS  = 17'd2880;

    localparam logic [63:0] Q63_ONE  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] PI_Q61   = 64'h6487_ED51_10B4_611A;
    localparam logic [63:0] STEP_Q63 = PI_Q61 / 64'd2880;

    // horner denominators and their 2^24 reciprocals (rounded up)
    localparam logic [7:0] SIN_D [6] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] COS_D [6] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [24:0] SIN_K [6] = '{
        (25'd16777216 + 25'd155) / 25'd156, (25'd16777216 + 25'd109) / 25'd110,
        (25'd16777216 + 25'd71) / 25'd72,   (25'd16777216 + 25'd41) / 25'd42,
        (25'd16777216 + 25'd19) / 25'd20,   (25'd16777216 + 25'd5) / 25'd6};
    localparam logic [24:0] COS_K [6] = '{
        (25'd16777216 + 25'd131) / 25'd132, (25'd16777216 + 25'd89) / 25'd90,
        (25'd16777216 + 25'd55) / 25'd56,   (25'd16777216 + 25'd29) / 25'd30,
        (25'd16777216 + 25'd11) / 25'd12,   (25'd16777216 + 25'd1) / 25'd2};

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } t_quad;

    // four 32x32 partial products: ll, lh, hl, hh
    typedef logic [3:0][63:0] t_pp;

    typedef struct packed {
        t_quad       quad;
        logic        swap;
        logic [11:0] m;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] ts;
        logic [63:0] tc;
        logic [7:0]  rs;
        logic [7:0]  rc;
        t_pp         pps;
        t_pp         ppc;
    } t_sc;

    // partial quotient: bytes already divided hold quotient digits
    typedef struct packed {
        logic [63:0] v;
        logic [7:0]  rem;
    } t_dv;

    function automatic t_pp mul_pp(input logic [63:0] a, input logic [63:0] b);
        t_pp p;
        p[0] = {32'd0, a[31:0]} * {32'd0, b[31:0]};
        p[1] = {32'd0, a[31:0]} * {32'd0, b[63:32]};
        p[2] = {32'd0, a[63:32]} * {32'd0, b[31:0]};
        p[3] = {32'd0, a[63:32]} * {32'd0, b[63:32]};
        return p;
    endfunction

    // floor(a * b / 2^63) from the partial products
    function automatic logic [63:0] mul_comb(input t_pp p);
        logic [63:0] mid;
        logic [63:0] hi;
        mid = {32'd0, p[0][63:32]} + {32'd0, p[1][31:0]} + {32'd0, p[2][31:0]};
        hi  = p[3] + {32'd0, p[1][63:32]} + {32'd0, p[2][63:32]} + {32'd0, mid[63:32]};
        return {hi[62:0], mid[31]};
    endfunction

    // two byte digits of floor(v / d), from digit top down, each through a reciprocal
    function automatic t_dv div_pair(input t_dv a, input int top, input logic [7:0] d,
                                     input logic [24:0] k);
        t_dv         o;
        logic [15:0] w;
        logic [40:0] pr;
        logic [7:0]  q;
        logic [15:0] qd;
        o = a;
        for (int j = top; j > top - 2; j--) begin
            w     = {o.rem, o.v[8*j +: 8]};
            pr    = {25'd0, w} * {16'd0, k};
            q     = pr[31:24];
            qd    = {8'd0, q} * {8'd0, d};
            w     = w - qd;
            o.rem = w[7:0];
            o.v[8*j +: 8] = q;
        end
        return o;
    endfunction

endpackage

@@ design/e2r_if.sv @@
`timescale 1ns / 1ps
interface e2r_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   roll_angle;
    logic signed [15:0]   pitch_angle;
    logic signed [15:0]   yaw_angle;

    modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface e2r_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] m_row0_col0;
    logic signed [15:0] m_row1_col0;
    logic signed [15:0] m_row2_col0;
    logic signed [15:0] m_row0_col1;
    logic signed [15:0] m_row1_col1;
    logic signed [15:0] m_row2_col1;
    logic signed [15:0] m_row0_col2;
    logic signed [15:0] m_row1_col2;
    logic signed [15:0] m_row2_col2;

    modport source (output valid, m_row0_col0, m_row1_col0, m_row2_col0, m_row0_col1,
                    m_row1_col1, m_row2_col1, m_row0_col2, m_row1_col2, m_row2_col2,
                    input ready);
    modport sink   (input valid, m_row0_col0, m_row1_col0, m_row2_col0, m_row0_col1,
                    m_row1_col1, m_row2_col1, m_row0_col2, m_row1_col2, m_row2_col2,
                    output ready);
endinterface

@@ design/e2r_sincos.sv @@
`timescale 1ns / 1ps
module e2r_sincos (
    input  logic                                i_clk,
    input  logic [e2r_pkg::SC_STAGES-1:0]       i_en,
    input  logic signed [e2r_pkg::ANG_W-1:0]    i_angle,
    output logic signed [31:0]                  o_sin,
    output logic signed [31:0]                  o_cos
);
    import e2r_pkg::*;

    localparam int NREG = SC_STAGES - 1;

    t_sc r_st [NREG];
    t_sc n_st [NREG];

    logic signed [31:0] r_sin, r_cos;
    logic signed [31:0] n_sin, n_cos;

    // stage 0: reduce to one turn, split into quadrant and octant argument
    always_comb begin
        logic signed [17:0] sa;
        logic [16:0] a;
        logic [16:0] r;
        sa = 18'(i_angle) + 18'sd46080;
        a  = sa[16:0];
        if (a >= 3 * TURN_STEPS)      a = a - 17'(3 * TURN_STEPS);
        else if (a >= 2 * TURN_STEPS) a = a - 17'(2 * TURN_STEPS);
        else if (a >= TURN_STEPS)     a = a - TURN_STEPS;
        n_st[0] = r_st[0];
        if (a >= 3 * QUARTER_STEPS) begin
            n_st[0].quad = QUAD_IV;
            r = a - 17'(3 * QUARTER_STEPS);
        end else if (a >= 2 * QUARTER_STEPS) begin
            n_st[0].quad = QUAD_III;
            r = a - 17'(2 * QUARTER_STEPS);
        end else if (a >= QUARTER_STEPS) begin
            n_st[0].quad = QUAD_II;
            r = a - QUARTER_STEPS;
        end else begin
            n_st[0].quad = QUAD_I;
            r = a;
        end
        n_st[0].swap = r > EIGHTH_STEPS;
        n_st[0].m    = n_st[0].swap ? 12'(QUARTER_STEPS - r) : r[11:0];
        n_st[0].ts   = Q63_ONE;
        n_st[0].tc   = Q63_ONE;
    end

    genvar k;
    generate
        for (k = 1; k < NREG; k++) begin : g_stage
            if (k == 1) begin : g_arg
                // radian argument in Q63
                always_comb begin
                    logic [75:0] px;
                    px = {64'd0, r_st[k-1].m} * {12'd0, STEP_Q63};
                    n_st[k]   = r_st[k-1];
                    n_st[k].x = px[63:0];
                end
            end else if (k == 2) begin : g_sqp
                always_comb begin
                    n_st[k]     = r_st[k-1];
                    n_st[k].pps = mul_pp(r_st[k-1].x, r_st[k-1].x);
                end
            end else if (k == 3) begin : g_sqc
                always_comb begin
                    n_st[k]    = r_st[k-1];
                    n_st[k].x2 = mul_comb(r_st[k-1].pps);
                end
            end else if (k < 40) begin : g_horner
                localparam int IDX = (k - 4) / 6;
                localparam int PH  = (k - 4) % 6;
                if (PH == 0) begin : g_p
                    always_comb begin
                        n_st[k]     = r_st[k-1];
                        n_st[k].pps = mul_pp(r_st[k-1].x2, r_st[k-1].ts);
                        n_st[k].ppc = mul_pp(r_st[k-1].x2, r_st[k-1].tc);
                    end
                end else if (PH == 1) begin : g_c
                    always_comb begin
                        n_st[k]    = r_st[k-1];
                        n_st[k].ts = mul_comb(r_st[k-1].pps);
                        n_st[k].tc = mul_comb(r_st[k-1].ppc);
                        n_st[k].rs = 8'd0;
                        n_st[k].rc = 8'd0;
                    end
                end else begin : g_d
                    // two quotient digits per stage, last stage subtracts from one
                    localparam int TOP = 11 - 2 * PH;
                    always_comb begin
                        t_dv ds;
                        t_dv dc;
                        ds = div_pair({r_st[k-1].ts, r_st[k-1].rs}, TOP,
                                      SIN_D[IDX], SIN_K[IDX]);
                        dc = div_pair({r_st[k-1].tc, r_st[k-1].rc}, TOP,
                                      COS_D[IDX], COS_K[IDX]);
                        n_st[k]    = r_st[k-1];
                        n_st[k].rs = ds.rem;
                        n_st[k].rc = dc.rem;
                        if (PH == 5) begin
                            n_st[k].ts = Q63_ONE - ds.v;
                            n_st[k].tc = Q63_ONE - dc.v;
                        end else begin
                            n_st[k].ts = ds.v;
                            n_st[k].tc = dc.v;
                        end
                    end
                end
            end else if (k == 40) begin : g_fsp
                always_comb begin
                    n_st[k]     = r_st[k-1];
                    n_st[k].pps = mul_pp(r_st[k-1].x, r_st[k-1].ts);
                end
            end else begin : g_fsc
                always_comb begin
                    n_st[k]    = r_st[k-1];
                    n_st[k].ts = mul_comb(r_st[k-1].pps);
                end
            end
        end

        for (k = 0; k < NREG; k++) begin : g_reg
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_st[k] <= n_st[k];
                end
            end
        end
    endgenerate

    // to Q30, undo the octant swap and apply quadrant signs
    always_comb begin
        logic [63:0] us, uc;
        logic signed [31:0] s, c, t;
        us = r_st[NREG-1].ts + 64'h1_0000_0000;
        uc = r_st[NREG-1].tc + 64'h1_0000_0000;
        s  = {1'b0, us[63:33]};
        c  = {1'b0, uc[63:33]};
        if (r_st[NREG-1].swap) begin
            t = s;
            s = c;
            c = t;
        end
        case (r_st[NREG-1].quad)
            QUAD_I: begin
                n_sin = s;
                n_cos = c;
            end
            QUAD_II: begin
                n_sin = c;
                n_cos = -s;
            end
            QUAD_III: begin
                n_sin = -s;
                n_cos = -c;
            end
            default: begin
                n_sin = -c;
                n_cos = s;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[SC_STAGES-1]) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

@@ design/euler_to_camera_rotation_matrix.sv @@
`timescale 1ns / 1ps
// Euler angles (roll, pitch, yaw in 1/64 degree) to a camera rotation matrix.
// Input channel i_ang carries one angle triple per beat; output channel o_mat
// carries the nine Q1.14 elements (OUT_FRAC_BITS fraction bits) of
// (Rz*Ry*Rx) * P, where P maps camera axes to vehicle axes.
// The pipeline has 48 stages: o_mat.valid rises when the input beat
// reaches the last of them.
// Each sine/cosine lane has 43 stages: reduction, Q63 argument, two for the
// square, six Horner terms of six stages each (partial products, product
// sum, four stages of two reciprocal quotient digits), two for the final
// sine product and the Q30 result register; then 5 matrix stages.
// Throughput is one beat per cycle while o_mat.ready is high; the longest
// path is one 32x32 multiply, one 64-bit add or two quotient digits.
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so a stalled receiver lets upstream bubbles close
// and the pipeline keeps taking beats until all 48 stages are full.
// Nothing is lost or repeated while o_mat.ready is low.
// Reset clears all valid bits; o_mat.valid is low the cycle after reset.
module euler_to_camera_rotation_matrix #(
    parameter int OUT_FRAC_BITS = e2r_pkg::DEF_OUT_FRAC_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    e2r_in_if.sink    i_ang,
    e2r_out_if.source o_mat
);
    import e2r_pkg::*;

    localparam int SH = 60 - OUT_FRAC_BITS;
    localparam int M0 = SC_STAGES;

    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] en;

    // stage load enables, closing bubbles from the output back
    always_comb begin
        en[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || o_mat.ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_ang.valid;
            end
            for (int k = 1; k < PIPE_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_ang.ready = en[0];

    // sine and cosine lanes
    logic signed [31:0] sx, cx, sy, cy, sz, cz;

    e2r_sincos u_roll (
        .i_clk   (i_clk),
        .i_en    (en[SC_STAGES-1:0]),
        .i_angle (i_ang.roll_angle),
        .o_sin   (sx),
        .o_cos   (cx)
    );

    e2r_sincos u_pitch (
        .i_clk   (i_clk),
        .i_en    (en[SC_STAGES-1:0]),
        .i_angle (i_ang.pitch_angle),
        .o_sin   (sy),
        .o_cos   (cy)
    );

    e2r_sincos u_yaw (
        .i_clk   (i_clk),
        .i_en    (en[SC_STAGES-1:0]),
        .i_angle (i_ang.yaw_angle),
        .o_sin   (sz),
        .o_cos   (cz)
    );

    function automatic logic signed [31:0] round30(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v >= 0) r = (v + 64'sd536870912) >>> 30;
        else        r = -((-v + 64'sd536870912) >>> 30);
        return r[31:0];
    endfunction

    function automatic logic [ELEM_W-1:0] finish(input logic signed [63:0] v);
        logic signed [63:0] half, lim, r;
        half = 64'sd1 <<< (SH - 1);
        lim  = 64'sd1 <<< OUT_FRAC_BITS;
        if (v >= 0) r = (v + half) >>> SH;
        else        r = -((-v + half) >>> SH);
        if (r > lim)  r = lim;
        if (r < -lim) r = -lim;
        return r[ELEM_W-1:0];
    endfunction

    // m0: two-factor products
    logic signed [63:0] r0_sysx, r0_sycx, r0_p00, r0_p10, r0_p21, r0_p22;
    logic signed [63:0] r0_szcx, r0_czcx, r0_szsx, r0_czsx;
    logic signed [31:0] r0_sy, r0_sz, r0_cz;

    always_ff @(posedge i_clk) begin
        if (en[M0]) begin
            r0_sysx <= sy * sx;
            r0_sycx <= sy * cx;
            r0_p00  <= cy * cz;
            r0_p10  <= sz * cy;
            r0_p21  <= cy * sx;
            r0_p22  <= cy * cx;
            r0_szcx <= sz * cx;
            r0_czcx <= cz * cx;
            r0_szsx <= sz * sx;
            r0_czsx <= cz * sx;
            r0_sy   <= sy;
            r0_sz   <= sz;
            r0_cz   <= cz;
        end
    end

    // m1: round the pitch-sine products back to Q30
    logic signed [31:0] r1_sysx, r1_sycx, r1_sy, r1_sz, r1_cz;
    logic signed [63:0] r1_p00, r1_p10, r1_p21, r1_p22;
    logic signed [63:0] r1_szcx, r1_czcx, r1_szsx, r1_czsx;

    always_ff @(posedge i_clk) begin
        if (en[M0+1]) begin
            r1_sysx <= round30(r0_sysx);
            r1_sycx <= round30(r0_sycx);
            r1_p00  <= r0_p00;
            r1_p10  <= r0_p10;
            r1_p21  <= r0_p21;
            r1_p22  <= r0_p22;
            r1_szcx <= r0_szcx;
            r1_czcx <= r0_czcx;
            r1_szsx <= r0_szsx;
            r1_czsx <= r0_czsx;
            r1_sy   <= r0_sy;
            r1_sz   <= r0_sz;
            r1_cz   <= r0_cz;
        end
    end

    // m2: third factor on the triple products
    logic signed [63:0] r2_q01, r2_q11, r2_q02, r2_q12;
    logic signed [63:0] r2_p00, r2_p10, r2_p21, r2_p22;
    logic signed [63:0] r2_szcx, r2_czcx, r2_szsx, r2_czsx;
    logic signed [31:0] r2_sy;

    always_ff @(posedge i_clk) begin
        if (en[M0+2]) begin
            r2_q01  <= r1_cz * r1_sysx;
            r2_q11  <= r1_sz * r1_sysx;
            r2_q02  <= r1_cz * r1_sycx;
            r2_q12  <= r1_sz * r1_sycx;
            r2_p00  <= r1_p00;
            r2_p10  <= r1_p10;
            r2_p21  <= r1_p21;
            r2_p22  <= r1_p22;
            r2_szcx <= r1_szcx;
            r2_czcx <= r1_czcx;
            r2_szsx <= r1_szsx;
            r2_czsx <= r1_czsx;
            r2_sy   <= r1_sy;
        end
    end

    // m3: sums with the axis permutation folded in
    logic signed [63:0] r3_e [9];

    always_ff @(posedge i_clk) begin
        if (en[M0+3]) begin
            r3_e[0] <= r2_szcx - r2_q01;
            r3_e[1] <= -(r2_q11 + r2_czcx);
            r3_e[2] <= -r2_p21;
            r3_e[3] <= -(r2_q02 + r2_szsx);
            r3_e[4] <= r2_czsx - r2_q12;
            r3_e[5] <= -r2_p22;
            r3_e[6] <= r2_p00;
            r3_e[7] <= r2_p10;
            r3_e[8] <= -(64'(r2_sy) <<< 30);
        end
    end

    // m4: output rounding and clamp
    logic [ELEM_W-1:0] r4_m [9];

    always_ff @(posedge i_clk) begin
        if (en[M0+4]) begin
            for (int i = 0; i < 9; i++) begin
                r4_m[i] <= finish(r3_e[i]);
            end
        end
    end

    assign o_mat.valid       = r_vld[PIPE_STAGES-1];
    assign o_mat.m_row0_col0 = r4_m[0];
    assign o_mat.m_row1_col0 = r4_m[1];
    assign o_mat.m_row2_col0 = r4_m[2];
    assign o_mat.m_row0_col1 = r4_m[3];
    assign o_mat.m_row1_col1 = r4_m[4];
    assign o_mat.m_row2_col1 = r4_m[5];
    assign o_mat.m_row0_col2 = r4_m[6];
    assign o_mat.m_row1_col2 = r4_m[7];
    assign o_mat.m_row2_col2 = r4_m[8];

    // a stalled output beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mat.valid && !o_mat.ready |=> o_mat.valid)
        else $error("output beat dropped under stall");

    // an empty first stage always takes a beat
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> i_ang.ready)
        else $error("input stalled with empty first stage");

    // nothing valid comes out right after reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_mat.valid)
        else $error("output valid right after reset");

    // clamp holds on m_row0_col0 and m_row2_col2 when the format fits the field
    generate
        if (OUT_FRAC_BITS <= ELEM_W - 2) begin : g_clamp_chk
            a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                o_mat.valid |->
                    ($signed(o_mat.m_row2_col2) <= (32'sd1 <<< OUT_FRAC_BITS)) &&
                    ($signed(o_mat.m_row2_col2) >= -(32'sd1 <<< OUT_FRAC_BITS)) &&
                    ($signed(o_mat.m_row0_col0) <= (32'sd1 <<< OUT_FRAC_BITS)) &&
                    ($signed(o_mat.m_row0_col0) >= -(32'sd1 <<< OUT_FRAC_BITS)))
                else $error("matrix element beyond unity");
        end
    endgenerate

endmodule

@@ tb/euler_to_camera_rotation_matrix_tb.sv @@
`timescale 1ns / 1ps
module euler_to_camera_rotation_matrix_tb;
    import e2r_pkg::*;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } t_angles;

    typedef struct {
        logic signed [15:0] e [9];
    } t_matrix;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        bit                 known;
        logic signed [15:0] e [9];
    } t_stim_row;

    localparam int N_RANDOM   = 1700;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = PIPE_STAGES + 10;
    localparam logic [63:0] STEP_RAD = PI_Q61 / 64'd2880;

    localparam string ELEM_NAME [9] = '{
        "m_row0_col0", "m_row1_col0", "m_row2_col0",
        "m_row0_col1", "m_row1_col1", "m_row2_col1",
        "m_row0_col2", "m_row1_col2", "m_row2_col2"};

    logic i_clk;
    logic i_rst_n;

    e2r_in_if  ang_if ();
    e2r_out_if mat_if ();

    euler_to_camera_rotation_matrix DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ang   (ang_if),
        .o_mat   (mat_if)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_matrix pending_matrices[$];
    int      n_errors = 0;
    int      n_typed_errors = 0;
    int      n_sent = 0;
    int      n_checked = 0;
    longint  cycle_count = 0;
    bit      stall_free;
    bit      long_holdoff = 1'b0;

    // floor(a * b / 2^63)
    function automatic logic [63:0] q63_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[126:63];
    endfunction

    function automatic longint round_away(input longint v, input int s);
        longint half;
        half = longint'(1) <<< (s - 1);
        if (v >= 0) return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    // sine and cosine in Q30 of an angle in 1/64 degree
    task automatic angle_sin_cos(input logic signed [15:0] ang,
                                 output longint s_q30, output longint c_q30);
        longint      a;
        longint      rem;
        longint      arg;
        longint      s;
        longint      c;
        longint      tmp;
        int          quad;
        bit          swap;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] ts;
        logic [63:0] tc;
        int          sin_den [6];
        int          cos_den [6];
        sin_den = '{156, 110, 72, 42, 20, 6};
        cos_den = '{132, 90, 56, 30, 12, 2};
        a = longint'(ang) % 23040;
        if (a < 0) a += 23040;
        quad = int'(a / 5760);
        rem  = a % 5760;
        swap = rem > 2880;
        arg  = swap ? 5760 - rem : rem;
        x  = 64'(arg) * STEP_RAD;
        x2 = q63_product(x, x);
        ts = Q63_ONE;
        tc = Q63_ONE;
        for (int i = 0; i < 6; i++) begin
            ts = Q63_ONE - q63_product(x2, ts) / 64'(sin_den[i]);
            tc = Q63_ONE - q63_product(x2, tc) / 64'(cos_den[i]);
        end
        ts = q63_product(x, ts);
        s = longint'((ts + (64'd1 << 32)) >> 33);
        c = longint'((tc + (64'd1 << 32)) >> 33);
        if (swap) begin
            tmp = s; s = c; c = tmp;
        end
        case (quad)
            0: begin s_q30 = s;  c_q30 = c;  end
            1: begin s_q30 = c;  c_q30 = -s; end
            2: begin s_q30 = -s; c_q30 = -c; end
            default: begin s_q30 = -c; c_q30 = s; end
        endcase
    endtask

    function automatic logic signed [15:0] to_element(input longint q60);
        longint lim;
        longint v;
        lim = longint'(1) <<< DEF_OUT_FRAC_BITS;
        v = round_away(q60, 60 - DEF_OUT_FRAC_BITS);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v[15:0];
    endfunction

    // camera rotation matrix of one angle triple
    task automatic camera_matrix(input t_angles a, output t_matrix m);
        longint sx, cx, sy, cy, sz, cz, sysx, sycx;
        angle_sin_cos(a.roll, sx, cx);
        angle_sin_cos(a.pitch, sy, cy);
        angle_sin_cos(a.yaw, sz, cz);
        sysx = round_away(sy * sx, 30);
        sycx = round_away(sy * cx, 30);
        m.e[0] = to_element(-(cz * sysx - sz * cx));
        m.e[1] = to_element(-(sz * sysx + cz * cx));
        m.e[2] = to_element(-(cy * sx));
        m.e[3] = to_element(-(cz * sycx + sz * sx));
        m.e[4] = to_element(-(sz * sycx - cz * sx));
        m.e[5] = to_element(-(cy * cx));
        m.e[6] = to_element(cy * cz);
        m.e[7] = to_element(sz * cy);
        m.e[8] = to_element(-sy * (longint'(1) <<< 30));
    endtask

    // directed rows; matrices typed in only for exact right angles
    t_stim_row directed_rows [] = '{
        '{16'sd0, 16'sd0, 16'sd0, 1'b1,
          '{16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384,
            16'sd16384, 16'sd0, 16'sd0}},
        '{16'sd5760, 16'sd0, 16'sd0, 1'b1,
          '{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd16384, 16'sd0,
            16'sd16384, 16'sd0, 16'sd0}},
        '{16'sd0, 16'sd0, 16'sd5760, 1'b1,
          '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd16384,
            16'sd0, 16'sd16384, 16'sd0}},
        '{16'sd0, 16'sd5760, 16'sd0, 1'b1,
          '{16'sd0, -16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0,
            16'sd0, 16'sd0, -16'sd16384}},
        '{16'sd23040, -16'sd23040, 16'sd11520, 1'b0, '{default: 16'sd0}},
        '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '{default: 16'sd0}},
        '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '{default: 16'sd0}},
        '{-16'sd1, 16'sd1, -16'sd1, 1'b0, '{default: 16'sd0}},
        '{16'sd2880, 16'sd2881, 16'sd2879, 1'b0, '{default: 16'sd0}},
        '{16'sd8640, 16'sd14400, 16'sd20160, 1'b0, '{default: 16'sd0}},
        '{16'sd11520, 16'sd17280, -16'sd5760, 1'b0, '{default: 16'sd0}},
        '{16'sd5759, 16'sd5761, 16'sd23039, 1'b0, '{default: 16'sd0}},
        '{16'sh5555, -16'sh5556, 16'sh2AAA, 1'b0, '{default: 16'sd0}}
    };

    // send one beat and record its expected matrix
    task automatic send_angles(input t_angles a, input bit has_typed, input t_matrix typed);
        t_matrix m;
        camera_matrix(a, m);
        if (has_typed) begin
            for (int i = 0; i < 9; i++)
                if (m.e[i] !== typed.e[i]) begin
                    $error("typed row mismatch %s: expected %0d predicted %0d",
                           ELEM_NAME[i], typed.e[i], m.e[i]);
                    n_typed_errors++;
                end
            m = typed;
        end
        ang_if.valid       <= 1'b1;
        ang_if.roll_angle  <= a.roll;
        ang_if.pitch_angle <= a.pitch;
        ang_if.yaw_angle   <= a.yaw;
        @(posedge i_clk);
        while (!ang_if.ready) @(posedge i_clk);
        pending_matrices.push_back(m);
        n_sent++;
    endtask

    function automatic logic signed [15:0] random_angle();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 23039));
            1: return -16'sd32768 + 16'($urandom_range(0, 3) * 23040 / 2);
            2: return 16'($urandom_range(0, 4) * 5760 + $urandom_range(0, 2) - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    // sender
    initial begin
        t_angles a;
        t_matrix typed;
        ang_if.valid       = 1'b0;
        ang_if.roll_angle  = '0;
        ang_if.pitch_angle = '0;
        ang_if.yaw_angle   = '0;
        i_rst_n      = 1'b0;
        stall_free   = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[r]) begin
            a.roll  = directed_rows[r].roll;
            a.pitch = directed_rows[r].pitch;
            a.yaw   = directed_rows[r].yaw;
            typed.e = directed_rows[r].e;
            send_angles(a, directed_rows[r].known, typed);
        end
        // pause until every pending matrix is out
        ang_if.valid <= 1'b0;
        wait (pending_matrices.size() == 0);
        @(posedge i_clk);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 200) stall_free <= 1'b1;
            a.roll  = random_angle();
            a.pitch = random_angle();
            a.yaw   = random_angle();
            send_angles(a, 1'b0, typed);
            if (!stall_free && !long_holdoff && $urandom_range(0, 7) == 0) begin
                ang_if.valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
        end
        ang_if.valid <= 1'b0;
        wait (pending_matrices.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("sent %0d angle triples (directed and random, incl. wraps and octant edges)",
                 n_sent);
        $display("checked %0d matrices under random stalls and a full-pipeline hold-off",
                 n_checked);
        if (n_errors == 0 && n_typed_errors == 0)
            $display("[euler_to_camera_rotation_matrix] OK");
        else
            $display("[euler_to_camera_rotation_matrix] ERROR");
        $finish;
    end

    // receiver ready: random stall bursts plus one long hold-off
    initial begin
        int burst;
        bit holdoff_done;
        holdoff_done = 1'b0;
        mat_if.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!holdoff_done && n_sent >= 300) begin
                holdoff_done = 1'b1;
                long_holdoff <= 1'b1;
                mat_if.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                long_holdoff <= 1'b0;
            end else if (!stall_free && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 15);
                mat_if.ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end else begin
                burst = $urandom_range(1, 20);
                mat_if.ready <= 1'b1;
                repeat (burst) @(posedge i_clk);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_matrix want;
        logic signed [15:0] got [9];
        if (i_rst_n && mat_if.valid && mat_if.ready) begin
            got = '{mat_if.m_row0_col0, mat_if.m_row1_col0, mat_if.m_row2_col0,
                    mat_if.m_row0_col1, mat_if.m_row1_col1, mat_if.m_row2_col1,
                    mat_if.m_row0_col2, mat_if.m_row1_col2, mat_if.m_row2_col2};
            if (pending_matrices.size() == 0) begin
                $error("matrix beat with none expected");
                n_errors++;
            end else begin
                want = pending_matrices.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got[i] !== want.e[i]) begin
                        $error("%s: expected %0d actual %0d", ELEM_NAME[i], want.e[i], got[i]);
                        n_errors++;
                    end
                n_checked++;
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("[euler_to_camera_rotation_matrix] ERROR");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
design/e2r_pkg.sv
design/e2r_if.sv
design/e2r_sincos.sv
design/euler_to_camera_rotation_matrix.sv
tb/euler_to_camera_rotation_matrix_tb.sv
